>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside of reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The condition must never be true outside of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

>>> sv/crc32hx_pkg.sv
// ----------------------------------------------------------------------------
// crc32hx_pkg
// Types, character codes, sequencer steps and CRC helpers of the hex ASCII
// frame encoder.
// ----------------------------------------------------------------------------
package crc32hx_pkg;

	// Reflected CRC-32 polynomial.
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;

	// Character codes.
	localparam logic [6:0] CHAR_OPEN  = 7'h3C;
	localparam logic [6:0] CHAR_CLOSE = 7'h0A;
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_A     = 7'h41;

	// Command queue geometry.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Output sequencer steps for one command.
	localparam logic [3:0] STEP_OPEN      = 4'd0;
	localparam logic [3:0] STEP_HI        = 4'd1;
	localparam logic [3:0] STEP_LO        = 4'd2;
	localparam logic [3:0] STEP_CRC_FIRST = 4'd3;
	localparam logic [3:0] STEP_CLOSE     = 4'd11;

	// Input transaction payload.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// Output transaction payload.
	typedef struct packed {
		logic [6:0] ascii_char;
		logic       frame_end;
	} out_item_t;

	// One classified byte handed from the front end to the serializer.
	typedef struct packed {
		logic        open;
		logic        last;
		logic [7:0]  data;
		logic [31:0] crc;
	} cmd_t;

	// CRC-32 table entry, reduced to constant logic by synthesis.
	function automatic logic [31:0] crc_table(input logic [7:0] idx);
		logic [31:0] v;
		v = {24'd0, idx};
		for (int k = 0; k < 8; k++) begin
			v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
		end
		return v;
	endfunction

	// Upper-case ASCII hex digit of one nibble.
	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] ext;
		ext = {3'd0, nib};
		return (nib < 4'd10) ? (CHAR_ZERO + ext) : (CHAR_A + ext - 7'd10);
	endfunction

endpackage

>>> sv/crc32hx_front.sv
// ----------------------------------------------------------------------------
// crc32hx_front
// Accepts payload bytes, marks the first byte of each frame, folds every byte
// into the running CRC and pushes one command per byte into the queue.
// ----------------------------------------------------------------------------
module crc32hx_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  crc32hx_pkg::in_item_t byte_item,
	input  logic                 queue_full,
	output logic                 push,
	output crc32hx_pkg::cmd_t    push_cmd
);

	logic [31:0] crc_q;
	logic        inside_q;
	logic [31:0] crc_next;

	// A byte is taken whenever the queue has room.
	assign byte_ready = !queue_full;
	assign push       = byte_valid && byte_ready;

	// One table step of the reflected CRC.
	assign crc_next = (crc_q >> 8) ^ crc32hx_pkg::crc_table(crc_q[7:0] ^ byte_item.data_byte);

	// Classified command; the CRC field is only used on the final byte.
	always_comb begin
		push_cmd.open = !inside_q;
		push_cmd.last = byte_item.last_byte;
		push_cmd.data = byte_item.data_byte;
		push_cmd.crc  = crc_next;
	end

	// Frame state advances on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= '0;
			inside_q <= 1'b0;
		end else if (push) begin
			crc_q    <= byte_item.last_byte ? 32'd0 : crc_next;
			inside_q <= !byte_item.last_byte;
		end
	end

endmodule

>>> sv/crc32hx_queue.sv
// ----------------------------------------------------------------------------
// crc32hx_queue
// Short first-in first-out queue of commands between the front end and the
// serializer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc32hx_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  crc32hx_pkg::cmd_t push_cmd,
	input  logic              pop,
	output logic              full,
	output logic              head_valid,
	output crc32hx_pkg::cmd_t head_cmd
);

	localparam logic [crc32hx_pkg::QUEUE_AW-1:0] PTR_LAST =
		crc32hx_pkg::QUEUE_AW'(crc32hx_pkg::QUEUE_DEPTH - 1);
	localparam logic [crc32hx_pkg::QUEUE_CW-1:0] COUNT_FULL =
		crc32hx_pkg::QUEUE_CW'(crc32hx_pkg::QUEUE_DEPTH);

	crc32hx_pkg::cmd_t                   entry_q [crc32hx_pkg::QUEUE_DEPTH];
	logic [crc32hx_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [crc32hx_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [crc32hx_pkg::QUEUE_CW-1:0]    count_q;

	assign full       = (count_q == COUNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full && !pop, "push into a full queue")
	`ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && !head_valid, "pop from an empty queue")
	`ASSERT_CLK(a_count_range, clk, arst_n, count_q <= COUNT_FULL, "queue count out of range")

endmodule

>>> sv/crc32hx_back.sv
// ----------------------------------------------------------------------------
// crc32hx_back
// Serializer: walks the steps of the command at the head of the queue and
// emits one ASCII character per cycle, unless stalled or idle, via a registered output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc32hx_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  crc32hx_pkg::cmd_t      head_cmd,
	output logic                   pop,
	output logic                   char_valid,
	input  logic                   char_ready,
	output crc32hx_pkg::out_item_t char_item
);

	logic                   char_valid_q;
	crc32hx_pkg::out_item_t char_item_q;
	logic                   busy_q;
	logic [3:0]             step_q;

	logic                   load;
	logic                   emit;
	logic [3:0]             step_start;
	logic [3:0]             step_stop;
	logic [3:0]             step_cur;
	logic [3:0]             crc_off;
	logic [2:0]             nib_idx;
	logic [31:0]            crc_shift;
	crc32hx_pkg::out_item_t char_next;

	// The output register takes a new character when empty or being drained.
	assign load = !char_valid_q || char_ready;
	assign emit = load && head_valid;

	// Step range of the head command.
	assign step_start = head_cmd.open ? crc32hx_pkg::STEP_OPEN : crc32hx_pkg::STEP_HI;
	assign step_stop  = head_cmd.last ? crc32hx_pkg::STEP_CLOSE : crc32hx_pkg::STEP_LO;
	assign step_cur   = busy_q ? step_q : step_start;
	assign pop        = emit && (step_cur == step_stop);

	// CRC bytes go out least-significant first, high nibble of each first.
	assign crc_off   = step_cur - crc32hx_pkg::STEP_CRC_FIRST;
	assign nib_idx   = crc_off[2:0] ^ 3'd1;
	assign crc_shift = head_cmd.crc >> {nib_idx, 2'b00};

	// Character for the current step.
	always_comb begin
		char_next.frame_end = 1'b0;
		case (step_cur)
			crc32hx_pkg::STEP_OPEN: begin
				char_next.ascii_char = crc32hx_pkg::CHAR_OPEN;
			end
			crc32hx_pkg::STEP_HI: begin
				char_next.ascii_char = crc32hx_pkg::hex_char(head_cmd.data[7:4]);
			end
			crc32hx_pkg::STEP_LO: begin
				char_next.ascii_char = crc32hx_pkg::hex_char(head_cmd.data[3:0]);
			end
			crc32hx_pkg::STEP_CLOSE: begin
				char_next.ascii_char = crc32hx_pkg::CHAR_CLOSE;
				char_next.frame_end  = 1'b1;
			end
			default: begin
				char_next.ascii_char = crc32hx_pkg::hex_char(crc_shift[3:0]);
			end
		endcase
	end

	// Step sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
			busy_q       <= 1'b0;
			step_q       <= '0;
		end else begin
			if (load) begin
				char_valid_q <= head_valid;
			end
			if (emit) begin
				busy_q <= (step_cur != step_stop);
				step_q <= step_cur + 4'd1;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (emit) begin
			char_item_q <= char_next;
		end
	end

	assign char_valid = char_valid_q;
	assign char_item  = char_item_q;

	`ASSERT_CLK(a_busy_has_head, clk, arst_n, busy_q |-> head_valid, "command left mid-sequence")
	`ASSERT_CLK(a_end_is_newline, clk, arst_n, (char_valid_q && char_item_q.frame_end) |-> (char_item_q.ascii_char == crc32hx_pkg::CHAR_CLOSE), "frame end on a non-newline character")

endmodule

>>> sv/crc32_hex_ascii_frame_encoder.sv
// Hex ASCII frame encoder with CRC-32. Frame payload bytes come in one per
// transaction with a mark on the final byte; characters go out one per
// transaction from a registered output, at most one per cycle. A frame's first
// byte yields '<' and two hex digits, a middle byte two digits, and the final
// byte its two digits, the eight digits of the reflected CRC-32 (seed 0, no
// final inversion, bytes least-significant first) and a newline flagged with
// frame_end. The output serializer sets the rate, since it sends all the characters
// of one command before it takes another. The CRC is updated as a byte is
// accepted, and a two-entry command queue lets the input side run ahead of the
// serializer; a byte's command is held in a queue entry, and its first character
// then goes out through the output register.
// ----------------------------------------------------------------------------
// crc32_hex_ascii_frame_encoder
// Top level: front end, command queue and serializer.
// ----------------------------------------------------------------------------
module crc32_hex_ascii_frame_encoder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_ready,
	input  crc32hx_pkg::in_item_t  byte_item,
	output logic                   char_valid,
	input  logic                   char_ready,
	output crc32hx_pkg::out_item_t char_item
);

	logic              push;
	crc32hx_pkg::cmd_t push_cmd;
	logic              queue_full;
	logic              pop;
	logic              head_valid;
	crc32hx_pkg::cmd_t head_cmd;

	// Classify bytes and run the CRC.
	crc32hx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// Decouple the two sides.
	crc32hx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Emit characters.
	crc32hx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item)
	);

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hex ASCII frame encoder with CRC-32. Payload
// bytes are sent as framed transactions with random gaps, and characters are
// taken with random stalls. Every accepted character is compared field by
// field with the expected character stream, given as text by a directed row
// or built by a local CRC-32 and hex encoder model.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int DIRECTED_ROWS    = 19;
	localparam int RANDOM_BYTES     = 250;
	localparam int END_DRAIN_CYCLES = 24;
	localparam int STALL_LIMIT      = 2000;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   byte_valid;
	logic                   byte_ready;
	crc32hx_pkg::in_item_t  byte_item;
	logic                   char_valid;
	logic                   char_ready;
	crc32hx_pkg::out_item_t char_item;

	// Model state: running CRC of the open frame and whether a frame is open.
	logic [31:0] frame_crc  = 32'd0;
	bit          frame_open = 1'b0;

	// Characters the encoder still owes, oldest first.
	crc32hx_pkg::out_item_t pending_chars[$];

	string hex_digits = "0123456789ABCDEF";
	int    mismatches    = 0;
	int    bytes_sent    = 0;
	int    frames_sent   = 0;
	int    chars_checked = 0;
	int    sender_calm   = 0;
	int    receiver_calm = 0;
	int    idle_cycles   = 0;

	// Directed rows. Where a row has text, that text is the exact character
	// stream expected; empty text means the model decides.
	crc32hx_pkg::in_item_t directed_in [DIRECTED_ROWS] = '{
		'{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{8'h5A, 1'b0}, '{8'hA5, 1'b1},
		'{8'h00, 1'b1}, '{8'hFF, 1'b1}, '{8'h01, 1'b1}, '{8'h80, 1'b1},
		'{8'h12, 1'b0}, '{8'h34, 1'b0}, '{8'h56, 1'b0}, '{8'h78, 1'b0},
		'{8'h9A, 1'b0}, '{8'hBC, 1'b0}, '{8'hDE, 1'b0}, '{8'hF0, 1'b1},
		'{8'h0A, 1'b0}, '{8'h3C, 1'b0}, '{8'h7F, 1'b1}
	};
	string directed_text [DIRECTED_ROWS] = '{
		"<00", "FF", "", "",
		"<0000000000\n", "<FF8DEF022D\n", "<0196300777\n", "",
		"", "", "", "",
		"", "", "", "",
		"", "", ""
	};

	crc32_hex_ascii_frame_encoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item)
	);

	// Free-running clock, 12 ns period.
	always #6 clk = ~clk;

	// Idle cycles before the next transaction, with occasional stretches of none.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	// Queue one expected character; only the newline closes a frame.
	task automatic add_char(input logic [6:0] ch);
		crc32hx_pkg::out_item_t c;
		c.ascii_char = ch;
		c.frame_end  = (ch == crc32hx_pkg::CHAR_CLOSE);
		pending_chars.insert(pending_chars.size(), c);
	endtask

	// Queue the two hex digits of one byte, high nibble first.
	task automatic add_hex_pair(input logic [7:0] b);
		byte hi;
		byte lo;
		hi = hex_digits.getc(int'(b[7:4]));
		lo = hex_digits.getc(int'(b[3:0]));
		add_char(hi[6:0]);
		add_char(lo[6:0]);
	endtask

	// Fold one payload byte into the frame CRC and, when asked, queue the
	// characters it causes.
	task automatic encode_byte(input crc32hx_pkg::in_item_t it, input bit record);
		logic [31:0] crc;
		if (!frame_open) begin
			if (record) begin
				add_char(crc32hx_pkg::CHAR_OPEN);
			end
			frame_open = 1'b1;
		end
		if (record) begin
			add_hex_pair(it.data_byte);
		end
		// Reflected CRC-32, one bit at a time.
		crc = frame_crc ^ {24'd0, it.data_byte};
		for (int k = 0; k < 8; k++) begin
			crc = crc[0] ? ((crc >> 1) ^ crc32hx_pkg::CRC_POLY) : (crc >> 1);
		end
		frame_crc = crc;
		// Closing byte: CRC least-significant byte first, then the newline.
		if (it.last_byte) begin
			if (record) begin
				for (int k = 0; k < 4; k++) begin
					add_hex_pair(frame_crc[8*k +: 8]);
				end
				add_char(crc32hx_pkg::CHAR_CLOSE);
			end
			frame_crc  = 32'd0;
			frame_open = 1'b0;
			frames_sent++;
		end
	endtask

	// Present one byte transaction after a random gap and book its characters.
	task automatic send_byte(input crc32hx_pkg::in_item_t it, input string typed);
		int  gap;
		byte ch;
		gap = draw_wait(sender_calm);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= it;
		do @(posedge clk); while (!byte_ready);
		if (typed.len() > 0) begin
			encode_byte(it, 1'b0);
			for (int i = 0; i < typed.len(); i++) begin
				ch = typed.getc(i);
				add_char(ch[6:0]);
			end
		end else begin
			encode_byte(it, 1'b1);
		end
		bytes_sent++;
	endtask

	// Stimulus: directed rows, then random frames, mostly short.
	initial begin
		crc32hx_pkg::in_item_t it;
		int                    frame_len;
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		byte_item  = '0;
		char_ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_byte(directed_in[i], directed_text[i]);
		end

		while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES) begin
			if ($urandom_range(0, 15) == 0) begin
				frame_len = $urandom_range(13, 40);
			end else begin
				frame_len = $urandom_range(1, 6);
			end
			for (int k = 0; k < frame_len; k++) begin
				it.data_byte = 8'($urandom_range(0, 255));
				it.last_byte = (k == frame_len - 1);
				send_byte(it, "");
			end
		end
		byte_valid <= 1'b0;

		// Drain the remaining characters, then watch for strays.
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (END_DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d payload bytes in %0d frames, checked %0d characters.",
			bytes_sent, frames_sent, chars_checked);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Character sink: random stalls, each accepted transaction checked in order.
	initial begin
		crc32hx_pkg::out_item_t want;
		int                     stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(receiver_calm);
			if (stall > 0) begin
				char_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			char_ready <= 1'b1;
			do @(posedge clk); while (!char_valid);
			if (pending_chars.size() == 0) begin
				$error("Unexpected character: ascii_char=%h frame_end=%b",
					char_item.ascii_char, char_item.frame_end);
				mismatches++;
			end else begin
				want = pending_chars.pop_front();
				if (char_item.ascii_char !== want.ascii_char) begin
					$error("ascii_char: expected %h, got %h",
						want.ascii_char, char_item.ascii_char);
					mismatches++;
				end
				if (char_item.frame_end !== want.frame_end) begin
					$error("frame_end: expected %b, got %b",
						want.frame_end, char_item.frame_end);
					mismatches++;
				end
				chars_checked++;
			end
		end
	end

	// Watchdog: end the run if no transaction moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && byte_ready) || (char_valid && char_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule

>>> files.f
+incdir+sv
sv/crc32hx_pkg.sv
sv/crc32hx_front.sv
sv/crc32hx_queue.sv
sv/crc32hx_back.sv
sv/crc32_hex_ascii_frame_encoder.sv
tb/sv/tb_top.sv
